FILE: rtl/double_ended_queue_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the double ended queue
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression must hold at every edge out of reset
`define DEQ_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define DEQ_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// types and codes shared by the double ended queue modules
// ----------------------------------------------------------------------------
package deq_pkg;

    // operation codes
    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_REAR   = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] client_id;
    } t_deq_in;

    typedef struct packed {
        logic signed [31:0] popped_id;
        logic [1:0]         status;
        logic [4:0]         occupancy;
        logic               is_empty;
    } t_deq_out;

    // result fields known at accept time
    typedef struct packed {
        logic       pop_hit;
        logic [1:0] status;
        logic [4:0] occupancy;
        logic       is_empty;
    } t_deq_res;

endpackage

FILE: rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// single port entry store, registered read
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    input  logic [31:0]                i_wdata,
    output logic [31:0]                o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // read data only moves on a read, so it holds while the result waits
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// head and count bookkeeping, entry addressing and result stage
// ----------------------------------------------------------------------------
`include "double_ended_queue_macros.svh"

module deq_ctrl #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  deq_pkg::t_deq_in              i_in_data,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output deq_pkg::t_deq_res             o_res,
    output logic                          o_mem_we,
    output logic                          o_mem_re,
    output logic [$clog2(CAPACITY)-1:0]   o_mem_addr,
    output logic [31:0]                   o_mem_wdata
);

    import deq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = AW + 1;

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic          r_valid;
    t_deq_res      r_res, n_res;

    logic          accept;
    logic          is_full, is_empty;
    logic          is_push;
    logic [AW-1:0] head_dec, head_inc, rear_pos;
    logic [CW-1:0] rear_off;
    logic [SW-1:0] rear_sum;
    logic [CW+4:0] occ_ext;
    logic          we, re;
    logic [AW-1:0] addr;

    assign o_in_stall = r_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign is_full  = (r_count == CW'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign is_push  = (i_in_data.operation == OP_PUSH_FRONT) ||
                      (i_in_data.operation == OP_PUSH_REAR);

    assign head_dec = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - 1'b1;
    assign head_inc = (r_head == AW'(CAPACITY - 1)) ? '0 : r_head + 1'b1;

    // rear slot: head + count for a push, head + count - 1 for a pop
    assign rear_off = is_push ? r_count : r_count - 1'b1;
    assign rear_sum = SW'(r_head) + SW'(rear_off);
    assign rear_pos = (rear_sum >= SW'(CAPACITY)) ? AW'(rear_sum - SW'(CAPACITY))
                                                  : AW'(rear_sum);

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        we          = 1'b0;
        re          = 1'b0;
        addr        = r_head;
        n_res       = '0;
        n_res.status = ST_DONE;
        case (i_in_data.operation)
            OP_PUSH_FRONT: begin
                if (is_full) begin
                    n_res.status = ST_FULL;
                end else begin
                    n_head  = head_dec;
                    addr    = head_dec;
                    we      = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            OP_PUSH_REAR: begin
                if (is_full) begin
                    n_res.status = ST_FULL;
                end else begin
                    addr    = rear_pos;
                    we      = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (is_empty) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    addr          = r_head;
                    re            = 1'b1;
                    n_head        = head_inc;
                    n_count       = r_count - 1'b1;
                    n_res.pop_hit = 1'b1;
                end
            end
            OP_POP_REAR: begin
                if (is_empty) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    addr          = rear_pos;
                    re            = 1'b1;
                    n_count       = r_count - 1'b1;
                    n_res.pop_hit = 1'b1;
                end
            end
            default: begin
                n_res.status = ST_DONE;
            end
        endcase
        occ_ext         = {5'b0, n_count};
        n_res.occupancy = occ_ext[4:0];
        n_res.is_empty  = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head  <= n_head;
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;
    assign o_mem_we    = accept && we;
    assign o_mem_re    = accept && re;
    assign o_mem_addr  = addr;
    assign o_mem_wdata = i_in_data.client_id;

    `DEQ_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY), "count above capacity")
    `DEQ_ASSERT_ALWAYS(a_head_bound, i_clk, i_rst_n, r_head <= AW'(CAPACITY - 1), "head out of ring")
    `DEQ_ASSERT_NEXT(a_refused_hold, i_clk, i_rst_n, accept && (n_res.status != ST_DONE), $stable(r_head) && $stable(r_count), "refused operation changed state")
    `DEQ_ASSERT_NEXT(a_push_count, i_clk, i_rst_n, accept && we, r_count == $past(r_count) + 1'b1, "push did not grow count")
    `DEQ_ASSERT_ALWAYS(a_mem_excl, i_clk, i_rst_n, !(o_mem_we && o_mem_re), "read and write in one cycle")

endmodule

FILE: rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded double ended queue of 32-bit identifiers in a ring buffer
// ----------------------------------------------------------------------------
// Holds up to CAPACITY identifiers in a single-port ring memory addressed by a
// head index and an entry count. Each input transfer carries one operation
// (push front, push rear, pop front, pop rear) and produces exactly one output
// transfer with the popped identifier (zero unless a pop succeeded), a status
// (done, pop refused because empty, push refused because full), the occupancy
// after the operation (reported modulo 32) and an empty flag. A refused
// operation leaves the contents untouched. The block takes one item per
// cycle while the output does not stall: head and count registers are updated
// in the accept cycle and the memory port serves at most one read or write,
// so the result and its registered read data appear in the cycle after the input.
// The result stage is a single register; a new item is accepted in the same
// cycle that the pending result is taken, and the input stalls only while a
// result is held by a stalled output. No clearing pass is needed after reset.
module double_ended_queue #(
    parameter int CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  deq_pkg::t_deq_in  i_in_data,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output deq_pkg::t_deq_out o_out_data
);

    import deq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    t_deq_res      res;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata;
    logic [31:0]   mem_rdata;

    // pointer bookkeeping and result stage
    deq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_re    (mem_re),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata)
    );

    // entry store, read data lands together with the result stage
    deq_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // popped identifier only on a successful pop, zero for everything else
    assign o_out_data.popped_id = res.pop_hit ? mem_rdata : '0;
    assign o_out_data.status    = res.status;
    assign o_out_data.occupancy = res.occupancy;
    assign o_out_data.is_empty  = res.is_empty;

endmodule

FILE: dv/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// watches both channels of the double ended queue and checks every result
// ----------------------------------------------------------------------------
// Keeps its own ring of identifiers, head position and fill level. Each input
// transfer is run through the deque rules to form the result it must cause.
// Each output transfer is compared field by field against the oldest result
// still due. The failure count and the number of results due go to the top.
// ----------------------------------------------------------------------------
module deq_checker #(
    parameter int CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  deq_pkg::t_deq_in  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  deq_pkg::t_deq_out i_out_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_empty_refusals,
    output int                o_full_refusals
);
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    logic [31:0] id_ring [CAPACITY];
    int unsigned front_pos;
    int unsigned fill_level;
    t_deq_out    due_results [$];

    initial begin
        o_fail_count     = 0;
        o_pending        = 0;
        o_empty_refusals = 0;
        o_full_refusals  = 0;
    end

    // applies one operation to the shadow ring and returns its result
    function automatic t_deq_out apply_deq_op(t_deq_in req);
        t_deq_out    res;
        int unsigned slot;
        res = '0;
        res.status = ST_DONE;
        case (req.operation)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (fill_level >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (req.operation == OP_PUSH_FRONT) begin
                    front_pos = (front_pos == 0) ? CAPACITY - 1 : front_pos - 1;
                    id_ring[front_pos] = req.client_id;
                    fill_level++;
                end else begin
                    slot = (front_pos + fill_level) % CAPACITY;
                    id_ring[slot] = req.client_id;
                    fill_level++;
                end
            end
            default: begin
                if (fill_level == 0) begin
                    res.status = ST_EMPTY;
                end else if (req.operation == OP_POP_FRONT) begin
                    res.popped_id = id_ring[front_pos];
                    front_pos = (front_pos + 1) % CAPACITY;
                    fill_level--;
                end else begin
                    slot = (front_pos + fill_level - 1) % CAPACITY;
                    res.popped_id = id_ring[slot];
                    fill_level--;
                end
            end
        endcase
        res.occupancy = 5'(fill_level);
        res.is_empty  = (fill_level == 0);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: mismatch on %s, got %0h, want %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_deq_out want;
        if (!i_rst_n) begin
            front_pos  = 0;
            fill_level = 0;
            due_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result with nothing due", i_out_data.popped_id, '0);
                end else begin
                    want = due_results.pop_front();
                    if (i_out_data.popped_id !== want.popped_id)
                        report_mismatch("popped_id", i_out_data.popped_id, want.popped_id);
                    if (i_out_data.status !== want.status)
                        report_mismatch("status", i_out_data.status, want.status);
                    if (i_out_data.occupancy !== want.occupancy)
                        report_mismatch("occupancy", i_out_data.occupancy, want.occupancy);
                    if (i_out_data.is_empty !== want.is_empty)
                        report_mismatch("is_empty", i_out_data.is_empty, want.is_empty);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = apply_deq_op(i_in_data);
                if (want.status == ST_EMPTY) o_empty_refusals++;
                if (want.status == ST_FULL) o_full_refusals++;
                due_results.push_back(want);
            end
        end
        o_pending = due_results.size();
    end

endmodule

FILE: dv/tb_double_ended_queue.sv
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// self-checking bench for the bounded double ended queue
// ----------------------------------------------------------------------------
// A directed opening hits both refusals, the signed extremes of the
// identifier, head wrap and a full fill. A random walk follows that swings
// between push-heavy and pop-heavy stretches so the ring hits full and empty
// again and again. Both sides idle in random bursts; the last stretch runs
// flat out. Checking lives in deq_checker.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int RANDOM_OPS  = 1300;
    localparam int TAIL_OPS    = 150;   // last stretch with no idling
    localparam int STALL_LIMIT = 1000;  // cycles without any transfer

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    t_deq_in  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_deq_out out_data;

    int       fail_count;
    int       pending;
    int       empty_refusals;
    int       full_refusals;
    int       op_count [4];
    int       quiet_cycles = 0;
    logic     tail_phase = 1'b0;

    double_ended_queue #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    deq_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_in_data        (in_data),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_data       (out_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_empty_refusals (empty_refusals),
        .o_full_refusals  (full_refusals)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // one transfer on the input channel; data is set at the falling edge and
    // held until an edge sees valid high with no stall
    task automatic send_op(input logic [1:0] op, input logic [31:0] id);
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= '{operation: op, client_id: id};
        op_count[op]++;
        do @(posedge i_clk); while (in_stall);
    endtask

    // sender gap, with junk on the data lines while valid is low
    task automatic sender_gap(input int cycles);
        @(negedge i_clk);
        in_valid <= 1'b0;
        in_data  <= '{operation: 2'($urandom), client_id: $urandom};
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // hold off the sender until every result due has been taken
    task automatic drain_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // mostly full-range random ids, sometimes a signed extreme or zero / all ones
    function automatic logic [31:0] pick_id();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // receiver stall: calm runs, short or long, each then a stall burst; none in the last stretch
    initial begin
        int run;
        forever begin
            if (tail_phase) begin
                @(negedge i_clk);
                out_stall <= 1'b0;
            end else begin
                run = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
                repeat (run) begin
                    @(negedge i_clk);
                    out_stall <= 1'b0;
                end
                repeat ($urandom_range(1, 8)) begin
                    @(negedge i_clk);
                    out_stall <= !tail_phase;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        logic       push_bias;
        logic       sender_calm;
        logic [1:0] op;

        foreach (op_count[k]) op_count[k] = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // refusals on an empty ring
        send_op(OP_POP_FRONT, 32'h1234_5678);
        send_op(OP_POP_REAR, 32'hffff_ffff);
        // signed extremes; push front from empty wraps the head
        send_op(OP_PUSH_FRONT, 32'h8000_0000);
        send_op(OP_PUSH_REAR, 32'h7fff_ffff);
        send_op(OP_POP_REAR, '0);
        send_op(OP_POP_FRONT, '0);
        // fill from both ends, then refused pushes on a full ring
        for (int k = 0; k < CAPACITY; k++) begin
            case (k % 4)
                0:       send_op(OP_PUSH_FRONT, 32'h0000_0000);
                1:       send_op(OP_PUSH_REAR, 32'hffff_ffff);
                2:       send_op(OP_PUSH_FRONT, 32'h5555_aaaa);
                default: send_op(OP_PUSH_REAR, $urandom);
            endcase
        end
        send_op(OP_PUSH_FRONT, 32'hdead_0001);
        send_op(OP_PUSH_REAR, 32'hdead_0002);
        drain_results();

        // random walk: push-heavy and pop-heavy stretches reach full and empty
        push_bias   = 1'b0;
        sender_calm = 1'b0;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n == RANDOM_OPS - TAIL_OPS) tail_phase = 1'b1;
            if (n == RANDOM_OPS / 2) drain_results();
            if ($urandom_range(0, 29) == 0) push_bias = !push_bias;
            if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
            if (!tail_phase && !sender_calm && $urandom_range(0, 4) == 0)
                sender_gap($urandom_range(1, 8));
            if (($urandom_range(0, 9) < 8) == push_bias)
                op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
            else
                op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
            send_op(op, pick_id());
        end

        // wait out the remaining results and any stray ones
        drain_results();
        repeat (10) @(negedge i_clk);

        $display("ops sent: %0d push front, %0d push rear, %0d pop front, %0d pop rear",
                 op_count[OP_PUSH_FRONT], op_count[OP_PUSH_REAR],
                 op_count[OP_POP_FRONT], op_count[OP_POP_REAR]);
        $display("refused: %0d pops on empty, %0d pushes on full, %0d mismatches",
                 empty_refusals, full_refusals, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
